[hw/rtl/njm_pkg.sv]
// ----------------------------------------------------------------------------
// njm_pkg
// Shared types, constants and the distance-compare function used by the
// nearest-jet delta-R matcher cells and tail stage.
// ----------------------------------------------------------------------------
package njm_pkg;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    localparam int ETA_W   = 14;
    localparam int PHI_W   = 13;
    localparam int CNT_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int RAD_W   = 13;
    localparam int AE_W    = 14;
    localparam int AP_W    = 12;
    localparam int DIST_W  = 28;
    localparam int BEST_W  = 26;
    localparam int DIFF_W  = 15;

    localparam logic signed [ETA_W-1:0]  ETA_LIMIT     = 14'sd5120;
    localparam logic signed [ETA_W-1:0]  ETA_LIMIT_NEG = -14'sd5120;
    localparam logic signed [PHI_W-1:0]  PHI_LIMIT     = 13'sd3217;
    localparam logic signed [PHI_W-1:0]  PHI_LIMIT_NEG = -13'sd3217;
    localparam logic signed [DIFF_W-1:0] PI_Q10        = 15'sd3217;
    localparam logic signed [DIFF_W-1:0] PI_Q10_NEG    = -15'sd3217;
    localparam logic signed [DIFF_W-1:0] TWO_PI_Q10    = 15'sd6434;

    localparam logic [RAD_W-1:0]  MATCH_RADIUS_RESET = 13'd410;
    localparam logic [BEST_W-1:0] THRESH_SQ_RESET    =
        26'(MATCH_RADIUS_RESET) * 26'(MATCH_RADIUS_RESET);

    typedef struct packed {
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
        logic [CNT_W-1:0]        count;
        logic                    found;
        logic [SLOT_W-1:0]       best_slot;
        logic [BEST_W-1:0]       best;
        logic                    pend;
        logic [AE_W-1:0]         pend_ae;
        logic [AP_W-1:0]         pend_ap;
    } tok_t;

    // Square the pending distance of the previous jet and keep it if closer.
    function automatic tok_t resolve(input tok_t t, input logic [SLOT_W-1:0] slot);
        logic [DIST_W-1:0] d;
        tok_t              r;
        r = t;
        d = DIST_W'(t.pend_ae) * DIST_W'(t.pend_ae)
          + DIST_W'(t.pend_ap) * DIST_W'(t.pend_ap);
        if (t.pend && (d < DIST_W'(t.best)))
        begin
            r.found     = 1'b1;
            r.best      = BEST_W'(d);
            r.best_slot = slot;
        end
        r.pend = 1'b0;
        return r;
    endfunction

endpackage

[hw/rtl/njm_cell.sv]
// ----------------------------------------------------------------------------
// njm_cell
// One jet slot of the matcher chain: holds a jet's eta/phi, settles the
// previous slot's distance and passes the query token on with its own
// wrapped coordinate differences.
// ----------------------------------------------------------------------------
module njm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load_en,
    input  logic signed [njm_pkg::ETA_W-1:0]    load_eta,
    input  logic signed [njm_pkg::PHI_W-1:0]    load_phi,
    input  logic                                valid_in,
    input  njm_pkg::tok_t                       tok_in,
    output logic                                valid_out,
    output njm_pkg::tok_t                       tok_out
);

    logic signed [njm_pkg::ETA_W-1:0]  jet_eta_reg;
    logic signed [njm_pkg::PHI_W-1:0]  jet_phi_reg;
    logic                              valid_reg;
    njm_pkg::tok_t                     tok_reg;
    njm_pkg::tok_t                     tok_next;
    njm_pkg::tok_t                     settled;
    logic signed [njm_pkg::DIFF_W-1:0] de;
    logic signed [njm_pkg::DIFF_W-1:0] dp;
    logic signed [njm_pkg::DIFF_W-1:0] dpw;
    logic                              live;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            jet_eta_reg <= load_eta;
            jet_phi_reg <= load_phi;
        end
    end

    always_comb
    begin
        settled = njm_pkg::resolve(tok_in, njm_pkg::SLOT_W'(CELL_IDX - 1));
        de  = njm_pkg::DIFF_W'(tok_in.eta) - njm_pkg::DIFF_W'(jet_eta_reg);
        dp  = njm_pkg::DIFF_W'(tok_in.phi) - njm_pkg::DIFF_W'(jet_phi_reg);
        if (dp >= njm_pkg::PI_Q10)
        begin
            dpw = dp - njm_pkg::TWO_PI_Q10;
        end
        else if (dp < njm_pkg::PI_Q10_NEG)
        begin
            dpw = dp + njm_pkg::TWO_PI_Q10;
        end
        else
        begin
            dpw = dp;
        end
        live = 32'(tok_in.count) > 32'(CELL_IDX);
        tok_next         = settled;
        tok_next.pend    = live;
        tok_next.pend_ae = de[njm_pkg::DIFF_W-1]
                         ? njm_pkg::AE_W'(-de) : njm_pkg::AE_W'(de);
        tok_next.pend_ap = dpw[njm_pkg::DIFF_W-1]
                         ? njm_pkg::AP_W'(-dpw) : njm_pkg::AP_W'(dpw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            tok_reg <= tok_next;
        end
    end

    assign valid_out = valid_reg;
    assign tok_out   = tok_reg;

endmodule

[hw/rtl/njm_tail.sv]
// ----------------------------------------------------------------------------
// njm_tail
// End of the matcher chain: settles the last slot's distance and registers
// the result with its one-cycle strobe.
// ----------------------------------------------------------------------------
module njm_tail #(
    parameter int LAST_SLOT = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  njm_pkg::tok_t                 tok_in,
    output logic                          done,
    output logic                          match_found,
    output logic [njm_pkg::SLOT_W-1:0]    match_slot
);

    njm_pkg::tok_t                  settled;
    logic                           done_reg;
    logic                           found_reg;
    logic [njm_pkg::SLOT_W-1:0]     slot_reg;

    always_comb
    begin
        settled = njm_pkg::resolve(tok_in, njm_pkg::SLOT_W'(LAST_SLOT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            found_reg <= settled.found;
            slot_reg  <= settled.found ? settled.best_slot : '0;
        end
    end

    assign done        = done_reg;
    assign match_found = found_reg;
    assign match_slot  = slot_reg;

    a_no_slot_without_match: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !found_reg |-> slot_reg == '0)
        else $error("match_slot nonzero with no match");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(valid_in))
        else $error("result strobe without a token");

    a_done_follows_token: assert property (@(posedge clk) disable iff (!rst_n)
        valid_in |=> done_reg)
        else $error("token lost at chain end");

endmodule

[hw/rtl/nearest_jet_delta_r_matcher.sv]
// ----------------------------------------------------------------------------
// nearest_jet_delta_r_matcher
// Jet table with delta-R nearest-neighbor query, one jet per chain cell.
// Load: no result; a load may follow every cycle while busy is low.
// Query: the token passes the head register, then one register per chain
//   cell, then the tail's compare stage, which raises the result strobe.
// Busy holds off start until the query token leaves the last cell.
// Reset: clears control, threshold = radius 410 squared; jet slots stay unset.
// ----------------------------------------------------------------------------
module nearest_jet_delta_r_matcher #(
    parameter int MAX_JETS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [njm_pkg::SLOT_W-1:0]          jet_slot,
    input  logic signed [njm_pkg::ETA_W-1:0]    coord_eta,
    input  logic signed [njm_pkg::PHI_W-1:0]    coord_phi,
    input  logic [njm_pkg::CNT_W-1:0]           jet_count,
    input  logic                                cfg_we,
    input  logic [njm_pkg::RAD_W-1:0]           cfg_wdata,
    output logic                                done,
    output logic                                match_found,
    output logic [njm_pkg::SLOT_W-1:0]          match_slot
);

    logic [njm_pkg::BEST_W-1:0]        thresh_sq_reg;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              accept;
    logic                              load_fire;
    logic                              query_fire;
    logic signed [njm_pkg::ETA_W-1:0]  eta_sat;
    logic signed [njm_pkg::PHI_W-1:0]  phi_sat;
    logic [MAX_JETS:0]                 chain_valid;
    njm_pkg::tok_t                     chain_tok [0:MAX_JETS];
    njm_pkg::tok_t                     head_next;
    logic                              head_valid_reg;
    njm_pkg::tok_t                     head_tok_reg;

    assign busy       = busy_reg && !chain_valid[MAX_JETS];
    assign accept     = start && !busy;
    assign load_fire  = accept && (op == njm_pkg::OP_LOAD);
    assign query_fire = accept && (op == njm_pkg::OP_QUERY);

    always_comb
    begin
        if (coord_eta > njm_pkg::ETA_LIMIT)
        begin
            eta_sat = njm_pkg::ETA_LIMIT;
        end
        else if (coord_eta < njm_pkg::ETA_LIMIT_NEG)
        begin
            eta_sat = njm_pkg::ETA_LIMIT_NEG;
        end
        else
        begin
            eta_sat = coord_eta;
        end
        if (coord_phi > njm_pkg::PHI_LIMIT)
        begin
            phi_sat = njm_pkg::PHI_LIMIT;
        end
        else if (coord_phi < njm_pkg::PHI_LIMIT_NEG)
        begin
            phi_sat = njm_pkg::PHI_LIMIT_NEG;
        end
        else
        begin
            phi_sat = coord_phi;
        end
    end

    always_comb
    begin
        head_next           = '0;
        head_next.eta       = eta_sat;
        head_next.phi       = phi_sat;
        head_next.count     = jet_count;
        head_next.best      = thresh_sq_reg;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (query_fire)
        begin
            busy_next = 1'b1;
        end
        else if (chain_valid[MAX_JETS])
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_sq_reg  <= njm_pkg::THRESH_SQ_RESET;
            busy_reg       <= 1'b0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thresh_sq_reg <= njm_pkg::BEST_W'(cfg_wdata) * njm_pkg::BEST_W'(cfg_wdata);
            end
            busy_reg       <= busy_next;
            head_valid_reg <= query_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_fire)
        begin
            head_tok_reg <= head_next;
        end
    end

    assign chain_valid[0] = head_valid_reg;
    assign chain_tok[0]   = head_tok_reg;

    for (genvar i = 0; i < MAX_JETS; i++)
    begin : g_cell
        logic load_en;
        assign load_en = load_fire && (32'(jet_slot) == i);
        njm_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load_en   (load_en),
            .load_eta  (eta_sat),
            .load_phi  (phi_sat),
            .valid_in  (chain_valid[i]),
            .tok_in    (chain_tok[i]),
            .valid_out (chain_valid[i+1]),
            .tok_out   (chain_tok[i+1])
        );
    end

    njm_tail #(
        .LAST_SLOT (MAX_JETS - 1)
    ) u_tail (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_in    (chain_valid[MAX_JETS]),
        .tok_in      (chain_tok[MAX_JETS]),
        .done        (done),
        .match_found (match_found),
        .match_slot  (match_slot)
    );

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one query in flight");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> chain_valid == '0)
        else $error("token in chain while idle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_fire |=> busy_reg && chain_valid[0])
        else $error("query transfer did not start the chain");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg))
        else $error("result without a pending query");

endmodule
